### hdl/assert_macros.svh
// shared assertion macros, clocked on clk and quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge
`define CHECK_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition that must hold in the cycle where the trigger is seen
`define CHECK_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define CHECK_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

### hdl/lea128_pkg.sv
package lea128_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned N_WORDS  = 4;
	localparam int unsigned N_ROUNDS = 24;
	localparam int unsigned KEY_W    = 64;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [N_WORDS-1:0] quad_t;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1
	} cfg_reg_t;

	// key schedule delta constants
	localparam word_t DELTA [N_WORDS] = '{
		32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
	};

	// rotate left by an amount that is constant at every use
	function automatic word_t lea_rotl(input word_t x, input int unsigned n);
		int unsigned m;
		m = n & (WORD_W - 1);
		return (x << m) | (x >> ((WORD_W - m) & (WORD_W - 1)));
	endfunction

	function automatic word_t lea_rotr(input word_t x, input int unsigned n);
		return lea_rotl(x, (WORD_W - (n & (WORD_W - 1))) & (WORD_W - 1));
	endfunction

	// round constant added to key word i in round r
	function automatic word_t lea_key_const(input int unsigned r, input int unsigned i);
		return lea_rotl(DELTA[r & (N_WORDS - 1)], (r + i) & (WORD_W - 1));
	endfunction

	// one step of the key schedule, t holds the previous round's words
	function automatic quad_t lea_key_step(input quad_t t, input quad_t rc);
		quad_t n;
		n[0] = lea_rotl(word_t'(t[0] + rc[0]), 1);
		n[1] = lea_rotl(word_t'(t[1] + rc[1]), 3);
		n[2] = lea_rotl(word_t'(t[2] + rc[2]), 6);
		n[3] = lea_rotl(word_t'(t[3] + rc[3]), 11);
		return n;
	endfunction

endpackage

### hdl/lea128_round.sv
// one pipeline stage: an ARX round on the block and the next key schedule step
module lea128_round import lea128_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  quad_t x_in,
	input  quad_t t_in,
	input  quad_t rc,
	output logic  vld_out,
	output quad_t x_out,
	output quad_t t_out
);

	logic  vld_s1;
	quad_t x_s1;
	quad_t t_s1;
	quad_t x_nxt;
	quad_t t_nxt;

	// round keys are t0, t1, t2, t1, t3, t1
	always_comb begin
		x_nxt[0] = lea_rotl(word_t'((x_in[0] ^ t_in[0]) + (x_in[1] ^ t_in[1])), 9);
		x_nxt[1] = lea_rotr(word_t'((x_in[1] ^ t_in[2]) + (x_in[2] ^ t_in[1])), 5);
		x_nxt[2] = lea_rotr(word_t'((x_in[2] ^ t_in[3]) + (x_in[3] ^ t_in[1])), 3);
		x_nxt[3] = x_in[0];
		t_nxt    = lea_key_step(t_in, rc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_nxt;
			t_s1 <= t_nxt;
		end
	end

	assign vld_out = vld_s1;
	assign x_out   = x_s1;
	assign t_out   = t_s1;

`include "assert_macros.svh"

	// a held stage keeps its block
	`CHECK_NEXT(a_stage_hold, vld_s1 && !en, $stable(x_s1), "stalled stage lost its block")

endmodule

### hdl/lea128_block_encrypt.sv
// channel | direction | handshake              | payload
// in      | into      | in_valid / in_ready    | plain_word0..plain_word3, 32 bits each
// out     | out of    | out_valid / out_ready  | cipher_word0..cipher_word3, 32 bits each
// cfg     | into      | cfg_valid / cfg_ready  | cfg_index (2 bits), cfg_data (64 bits)
//
// one block per cycle sustained while out_ready stays high: an input register that also runs
// the first key schedule step, then 24 round stages, one ARX round each
// the last round stage is the output register
// reset clears the valid bits and both key registers; cfg_ready is always high
// a stall at the output fills empty stages first, in_ready drops only when all are full or in reset
module lea128_block_encrypt import lea128_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// plaintext channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [WORD_W-1:0]     plain_word0,
	input  logic [WORD_W-1:0]     plain_word1,
	input  logic [WORD_W-1:0]     plain_word2,
	input  logic [WORD_W-1:0]     plain_word3,
	// ciphertext channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_W-1:0]     cipher_word0,
	output logic [WORD_W-1:0]     cipher_word1,
	output logic [WORD_W-1:0]     cipher_word2,
	output logic [WORD_W-1:0]     cipher_word3,
	// register write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [KEY_W-1:0]      cfg_data
);

	// key registers; the user must write them only while the pipe is empty, the block does not enforce it
	logic [KEY_W-1:0] key_low_q;
	logic [KEY_W-1:0] key_high_q;

	// stage 0 (input register) plus one stage per round
	logic  [N_ROUNDS:0] stage_vld;
	logic  [N_ROUNDS:0] stage_en;
	quad_t              stage_x [N_ROUNDS+1];
	quad_t              stage_t [N_ROUNDS+1];
	quad_t              stage_rc [N_ROUNDS+1];

	logic  vld_s0;
	quad_t x_s0;
	quad_t t_s0;
	quad_t key_words;
	logic  in_take;
	logic  out_take;

	// ---------------------------------------------------------------
	// configuration: every write transaction is taken at once
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stall chain: a stage loads when it is empty or its successor moves
	// ---------------------------------------------------------------
	always_comb begin
		stage_en[N_ROUNDS] = !stage_vld[N_ROUNDS] || out_ready;
		for (int k = N_ROUNDS - 1; k >= 0; k--) begin
			stage_en[k] = !stage_vld[k] || stage_en[k+1];
		end
	end

	// held low in reset so no transaction is counted before the pipe can run
	assign in_ready = stage_en[0] && arst_n;
	assign in_take  = in_valid && in_ready;

	// ---------------------------------------------------------------
	// stage 0: register the plaintext and the round 0 key words
	// ---------------------------------------------------------------
	assign key_words[0] = key_low_q[WORD_W-1:0];
	assign key_words[1] = key_low_q[KEY_W-1:WORD_W];
	assign key_words[2] = key_high_q[WORD_W-1:0];
	assign key_words[3] = key_high_q[KEY_W-1:WORD_W];

	for (genvar k = 0; k <= N_ROUNDS; k++) begin : g_rc
		for (genvar i = 0; i < N_WORDS; i++) begin : g_word
			assign stage_rc[k][i] = lea_key_const(k, i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (stage_en[0]) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			x_s0 <= {plain_word3, plain_word2, plain_word1, plain_word0};
			t_s0 <= lea_key_step(key_words, stage_rc[0]);
		end
	end

	assign stage_vld[0] = vld_s0;
	assign stage_x[0]   = x_s0;
	assign stage_t[0]   = t_s0;

	// ---------------------------------------------------------------
	// round stages: stage k applies round k-1 and derives round k keys
	// ---------------------------------------------------------------
	for (genvar k = 1; k <= N_ROUNDS; k++) begin : g_round
		lea128_round u_round (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (stage_en[k]),
			.vld_in  (stage_vld[k-1]),
			.x_in    (stage_x[k-1]),
			.t_in    (stage_t[k-1]),
			.rc      (stage_rc[k]),
			.vld_out (stage_vld[k]),
			.x_out   (stage_x[k]),
			.t_out   (stage_t[k])
		);
	end

	// ---------------------------------------------------------------
	// output: the last round stage is the output register
	// ---------------------------------------------------------------
	assign out_valid    = stage_vld[N_ROUNDS];
	assign out_take     = out_valid && out_ready;
	assign cipher_word0 = stage_x[N_ROUNDS][0];
	assign cipher_word1 = stage_x[N_ROUNDS][1];
	assign cipher_word2 = stage_x[N_ROUNDS][2];
	assign cipher_word3 = stage_x[N_ROUNDS][3];

`include "assert_macros.svh"

	// back pressure reaches the input only when every stage holds a block
	`CHECK_SAME(a_full_stall, !in_ready, &stage_vld, "input stalled with a bubble in the pipe")

	// an accepted transaction lands in the input register
	`CHECK_NEXT(a_take_lands, in_take, stage_vld[0], "accepted block not registered")

	// blocks in flight change only by transactions on the two channels
	`CHECK_ALWAYS(a_count_kept,
		$countones(stage_vld) == $past($countones(stage_vld)) + $past(in_take) - $past(out_take),
		"block lost or duplicated in the pipe")

endmodule

### verif/tb_top.sv
module tb_top import lea128_pkg::*;;

	// clock and run control
	localparam int unsigned CLK_HALF      = 10;
	localparam int unsigned RESET_CYCLES  = 9;
	localparam int unsigned PIPE_LATENCY  = 25;
	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned PHASE_BLOCKS  = 100;
	localparam int unsigned LONG_HOLD     = 200;

	// register indexes that decode to nothing, writes there must leave the key alone
	localparam logic [1:0] REG_SPARE_2 = 2'd2;
	localparam logic [1:0] REG_SPARE_3 = 2'd3;

	// key schedule constants of the cipher
	localparam word_t KEY_DELTA [N_WORDS] = '{
		32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
	};

	// expected ciphertexts, worked out from the key and each accepted plaintext
	class cipher_scoreboard;
		word_t       key_word [N_WORDS];
		quad_t       cipher_due [$];
		int unsigned errors;

		function new();
			for (int i = 0; i < N_WORDS; i++)
				key_word[i] = '0;
			errors = 0;
		endfunction

		function void write_key(input logic [1:0] idx, input logic [KEY_W-1:0] data);
			case (idx)
			REG_KEY_LOW: begin
				key_word[0] = data[31:0];
				key_word[1] = data[63:32];
			end
			REG_KEY_HIGH: begin
				key_word[2] = data[31:0];
				key_word[3] = data[63:32];
			end
			default: ;
			endcase
		endfunction

		function word_t rotl(input word_t v, input int unsigned n);
			return (v << n) | (v >> (WORD_W - n));
		endfunction

		function word_t rotr(input word_t v, input int unsigned n);
			return rotl(v, WORD_W - n);
		endfunction

		// key schedule runs alongside the rounds, one step per round
		function quad_t lea_encrypt(input quad_t plain);
			word_t rk [N_WORDS];
			quad_t x;
			word_t d, n0, n1, n2;
			rk = key_word;
			x = plain;
			for (int r = 0; r < N_ROUNDS; r++) begin
				d = KEY_DELTA[r % N_WORDS];
				rk[0] = rotl(rk[0] + rotl(d, r), 1);
				rk[1] = rotl(rk[1] + rotl(d, r + 1), 3);
				rk[2] = rotl(rk[2] + rotl(d, r + 2), 6);
				rk[3] = rotl(rk[3] + rotl(d, r + 3), 11);
				n0 = rotl((x[0] ^ rk[0]) + (x[1] ^ rk[1]), 9);
				n1 = rotr((x[1] ^ rk[2]) + (x[2] ^ rk[1]), 5);
				n2 = rotr((x[2] ^ rk[3]) + (x[3] ^ rk[1]), 3);
				x[3] = x[0];
				x[0] = n0;
				x[1] = n1;
				x[2] = n2;
			end
			return x;
		endfunction

		function void note_block(input quad_t plain);
			cipher_due.push_back(lea_encrypt(plain));
		endfunction

		function void check_cipher(input quad_t got);
			quad_t want;
			if (cipher_due.size() == 0) begin
				errors++;
				$display("%0t: ciphertext %h with none outstanding", $time, got);
				return;
			end
			want = cipher_due.pop_front();
			for (int i = 0; i < N_WORDS; i++)
				if (got[i] !== want[i]) begin
					errors++;
					$display("%0t: cipher_word%0d expected %h actual %h",
						$time, i, want[i], got[i]);
				end
		endfunction

		function int unsigned pending();
			return cipher_due.size();
		endfunction
	endclass

	// every block input starts at a known value
	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [WORD_W-1:0] plain_word0 = '0;
	logic [WORD_W-1:0] plain_word1 = '0;
	logic [WORD_W-1:0] plain_word2 = '0;
	logic [WORD_W-1:0] plain_word3 = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [WORD_W-1:0] cipher_word0;
	logic [WORD_W-1:0] cipher_word1;
	logic [WORD_W-1:0] cipher_word2;
	logic [WORD_W-1:0] cipher_word3;
	logic              cfg_valid   = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index   = '0;
	logic [KEY_W-1:0]  cfg_data    = '0;

	// steady turns off the random idling on both sides, hold_req asks for one long output stall
	bit                steady      = 1'b0;
	bit                hold_req    = 1'b0;
	int unsigned       cycle_count = 0;

	cipher_scoreboard sb = new();

	lea128_block_encrypt i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.plain_word0  (plain_word0),
		.plain_word1  (plain_word1),
		.plain_word2  (plain_word2),
		.plain_word3  (plain_word3),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cipher_word0 (cipher_word0),
		.cipher_word1 (cipher_word1),
		.cipher_word2 (cipher_word2),
		.cipher_word3 (cipher_word3),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// watchdog, generous against the slowest legal run with every stall at its longest
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// idle lengths: mostly short, now and then long
	function automatic int unsigned idle_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 75)
			return $urandom_range(1, 3);
		else if (p < 95)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// plaintext words lean on the all-zero and all-one extremes now and then
	function automatic word_t rand_word();
		case ($urandom_range(0, 15))
		0:       return '0;
		1:       return '1;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		case ($urandom_range(0, 7))
		0:       return '0;
		1:       return '1;
		2:       return {32'h0, $urandom};
		3:       return {$urandom, 32'hffff_ffff};
		default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic quad_t make_block(input word_t w0, input word_t w1,
		input word_t w2, input word_t w3);
		return {w3, w2, w1, w0};
	endfunction

	// offer one plaintext from the falling edge, held until the transaction completes
	task automatic send_block(input quad_t blk);
		@(negedge clk);
		in_valid    = 1'b1;
		plain_word0 = blk[0];
		plain_word1 = blk[1];
		plain_word2 = blk[2];
		plain_word3 = blk[3];
		do @(posedge clk); while (!in_ready);
		sb.note_block(blk);
	endtask

	// drop valid for a stretch set by n, the payload is scrambled meanwhile since nobody looks at it
	task automatic hold_input(input int unsigned n);
		@(negedge clk);
		in_valid    = 1'b0;
		plain_word0 = $urandom;
		plain_word1 = $urandom;
		plain_word2 = $urandom;
		plain_word3 = $urandom;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_random(input int unsigned count, input bit with_gaps);
		quad_t blk;
		for (int unsigned i = 0; i < count; i++) begin
			for (int j = 0; j < N_WORDS; j++)
				blk[j] = rand_word();
			send_block(blk);
			if (with_gaps && !steady && $urandom_range(0, 99) < 30)
				hold_input(idle_len());
		end
		hold_input(1);
	endtask

	// register write transaction, the key model follows only once it is accepted
	task automatic write_reg(input logic [1:0] idx, input logic [KEY_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_key(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// every ciphertext back, then let the pipeline settle
	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// output side: random back-pressure, plus one long stall on request
	initial begin : ready_driver
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				out_ready = 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else if (hold_req) begin
				// long stretch so the pipeline fills and in_ready drops
				hold_req   = 1'b0;
				stall_left = LONG_HOLD - 1;
				out_ready  = 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 30) begin
				stall_left = idle_len() - 1;
				out_ready  = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// every completed output transaction goes to the scoreboard
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_cipher({cipher_word3, cipher_word2, cipher_word1, cipher_word0});

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, back to back, first under the all-zero reset key
		steady = 1'b1;
		send_block(make_block('0, '0, '0, '0));
		send_block(make_block('1, '1, '1, '1));
		send_block(make_block(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa));
		send_block(make_block('1, '0, '0, '0));
		send_block(make_block('0, '1, '0, '0));
		send_block(make_block('0, '0, '1, '0));
		send_block(make_block('0, '0, '0, '1));
		hold_input(1);
		wait_drained();

		// all-ones key, then writes to the undecoded indexes which must change nothing
		write_reg(REG_KEY_LOW, '1);
		write_reg(REG_KEY_HIGH, '1);
		write_reg(REG_SPARE_2, {$urandom, $urandom});
		write_reg(REG_SPARE_3, {$urandom, $urandom});
		send_block(make_block('0, '0, '0, '0));
		send_block(make_block('1, '1, '1, '1));
		hold_input(1);
		wait_drained();

		// byte-ordered key and plaintext, the usual known-answer pattern
		write_reg(REG_KEY_LOW, 64'h7869_5a4b_3c2d_1e0f);
		write_reg(REG_KEY_HIGH, 64'hf0e1_d2c3_b4a5_9687);
		send_block(make_block(32'h1312_1110, 32'h1716_1514, 32'h1b1a_1918, 32'h1f1e_1d1c));
		send_block(make_block('0, '0, '0, '0));
		hold_input(1);
		wait_drained();

		// key change on one half only, the next block must see it
		write_reg(REG_KEY_LOW, '0);
		send_block(make_block(32'h1312_1110, 32'h1716_1514, 32'h1b1a_1918, 32'h1f1e_1d1c));
		hold_input(1);
		wait_drained();
		steady = 1'b0;

		// random phases, each under its own key setting
		for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			if (p == 0) begin
				write_reg(REG_KEY_LOW, '0);
				write_reg(REG_KEY_HIGH, '1);
			end else begin
				case ($urandom_range(0, 3))
				0:       write_reg(REG_KEY_LOW, rand_key());
				1:       write_reg(REG_KEY_HIGH, rand_key());
				default: begin
					write_reg(REG_KEY_LOW, rand_key());
					write_reg(REG_KEY_HIGH, rand_key());
				end
				endcase
			end
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					{$urandom, $urandom});
			// change control bits on a rising edge, clear of the ready driver
			@(posedge clk);
			steady = (p == 4);
			if (p == 3) begin
				// output held off while the sender keeps pushing with no gaps
				hold_req = 1'b1;
				send_random(PHASE_BLOCKS, 1'b0);
			end else if (p == 1) begin
				// sender pauses halfway until every ciphertext is back
				send_random(PHASE_BLOCKS / 2, 1'b1);
				wait_drained();
				send_random(PHASE_BLOCKS - PHASE_BLOCKS / 2, 1'b1);
			end else begin
				send_random(PHASE_BLOCKS, 1'b1);
			end
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/lea128_pkg.sv
hdl/lea128_round.sv
hdl/lea128_block_encrypt.sv
verif/tb_top.sv
